// ----- design/unv_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 name validator package
// Shared payload types, classification codes and constants.
// ----------------------------------------------------------------------------
package unv_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned POINT_W     = 21;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(12);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

  // Input request as it arrives on the input channel.
  typedef struct packed {
    logic [BYTE_W-1:0] name_byte;
    logic              byte_present;
    logic              end_of_name;
  } in_item_t;

  // Verdict request on the result channel.
  typedef struct packed {
    logic               name_valid;
    logic [COUNT_W-1:0] code_point_total;
    logic               visible_found;
  } out_item_t;

  // How a byte behaves when it is taken as a lead byte.
  typedef enum logic [2:0] {
    KIND_REJECT,
    KIND_SINGLE,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4
  } lead_kind_t;

  // Classified request passed from the front part to the back part.
  typedef struct packed {
    lead_kind_t        kind;
    logic              cont_ok;
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
  } cls_item_t;

endpackage

// ----- design/utf8_name_validator.sv -----
// A final request is written into the queue and, once popped, its verdict is
// registered in the output register before it shows on the output.
// Throughput: one byte per cycle unless output stalls; the two-entry queue
// and the single output register let input and output stall independently.
// Reset (synchronous, rst_n low) empties the queue, drops any pending verdict,
// clears all per-name state and sets the code point limit to twelve.
// ----------------------------------------------------------------------------
// UTF-8 name validator
// Checks the UTF-8 lead and continuation structure of a byte stream, counts
// code points and gives one verdict per name.
// ----------------------------------------------------------------------------
module utf8_name_validator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  unv_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output unv_pkg::out_item_t          out_item,
  input  logic                        cfg_wr_en,
  input  logic [unv_pkg::LIMIT_W-1:0] cfg_wr_data
);

  // The front end classifies each byte as it is accepted: how it would act
  // as a lead byte and whether it is a valid continuation byte. Both views
  // travel with the request because only the back end knows which applies.
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_not_empty;
  unv_pkg::cls_item_t q_push_data;
  unv_pkg::cls_item_t q_head;

  unv_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // The queue decouples the two halves, so input can keep flowing while a
  // finished verdict waits for the output side.
  unv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The back end holds the decoder state and the limit register. It pops a
  // request every cycle, except a final one while the output register is
  // still occupied and stalled.
  unv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ----- design/unv_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 name validator front end
// Accepts input requests and classifies each byte both as a lead byte and as
// a continuation byte before it enters the queue.
// ----------------------------------------------------------------------------
module unv_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  unv_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output unv_pkg::cls_item_t q_data
);

  unv_pkg::lead_kind_t kind;
  logic [unv_pkg::BYTE_W-1:0] b;

  assign b = in_item.name_byte;

  always_comb begin
    if ((b < 8'h20) || (b == 8'h7F)) begin
      kind = unv_pkg::KIND_REJECT;
    end else if (b >= 8'hF0) begin
      kind = unv_pkg::KIND_LEAD4;
    end else if (b >= 8'hE0) begin
      kind = unv_pkg::KIND_LEAD3;
    end else if (b >= 8'hC0) begin
      kind = unv_pkg::KIND_LEAD2;
    end else begin
      kind = unv_pkg::KIND_SINGLE;
    end
  end

  assign in_stall        = q_full;
  assign q_push          = in_valid & ~q_full;
  assign q_data.kind     = kind;
  assign q_data.cont_ok  = (b[7:6] == 2'b10);
  assign q_data.data     = b;
  assign q_data.present  = in_item.byte_present;
  assign q_data.last     = in_item.end_of_name;

endmodule

// ----- design/unv_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-8 name validator queue
// Short FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module unv_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  unv_pkg::cls_item_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output unv_pkg::cls_item_t head
);

  unv_pkg::cls_item_t          mem_r [unv_pkg::QUEUE_DEPTH];
  logic [unv_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [unv_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [unv_pkg::QCNT_W-1:0]  count_r, count_nxt;

  localparam logic [unv_pkg::QPTR_W-1:0] LAST_PTR =
    unv_pkg::QPTR_W'(unv_pkg::QUEUE_DEPTH - 1);
  localparam logic [unv_pkg::QCNT_W-1:0] FULL_CNT =
    unv_pkg::QCNT_W'(unv_pkg::QUEUE_DEPTH);

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/unv_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 name validator back end
// Decodes classified bytes, counts code points, forms the verdict and holds
// it in the output register.
// ----------------------------------------------------------------------------
module unv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [unv_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                        q_not_empty,
  input  unv_pkg::cls_item_t          q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output unv_pkg::out_item_t          out_item
);

  logic [unv_pkg::LIMIT_W-1:0] limit_r;
  logic [1:0]                  pending_r, pending_nxt;
  logic [unv_pkg::POINT_W-1:0] partial_r, partial_nxt;
  logic [unv_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        visible_r, visible_nxt;
  logic                        failed_r, failed_nxt;
  logic                        any_byte_r, any_byte_nxt;
  logic                        out_valid_r, out_valid_nxt;
  unv_pkg::out_item_t          out_item_r, out_item_nxt;

  function automatic logic is_invisible(input logic [unv_pkg::POINT_W-1:0] cp);
    return (cp == 21'h20) || (cp == 21'hA0) ||
           ((cp >= 21'h2000) && (cp <= 21'h200F)) ||
           (cp == 21'h2028) || (cp == 21'h2029) || (cp == 21'h202F) ||
           (cp == 21'h205F) || (cp == 21'h2060) || (cp == 21'h3000) ||
           (cp == 21'hFEFF);
  endfunction

  // A final request can only leave the queue when the output register is
  // free or is being emptied in this cycle.
  assign q_pop = q_not_empty & (~q_head.last | ~out_valid_r | ~out_stall);

  always_comb begin
    logic                        finish;
    logic [unv_pkg::POINT_W-1:0] cp;
    logic [unv_pkg::POINT_W-1:0] shifted;

    finish        = 1'b0;
    cp            = '0;
    shifted       = {partial_r[unv_pkg::POINT_W-7:0], q_head.data[5:0]};
    pending_nxt   = pending_r;
    partial_nxt   = partial_r;
    count_nxt     = count_r;
    visible_nxt   = visible_r;
    failed_nxt    = failed_r;
    any_byte_nxt  = any_byte_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (q_pop) begin
      if (q_head.present) begin
        any_byte_nxt = 1'b1;
        if (!failed_r) begin
          if (pending_r == 2'd0) begin
            unique case (q_head.kind)
              unv_pkg::KIND_REJECT: failed_nxt = 1'b1;
              unv_pkg::KIND_LEAD4: begin
                partial_nxt = unv_pkg::POINT_W'(q_head.data[2:0]);
                pending_nxt = 2'd3;
              end
              unv_pkg::KIND_LEAD3: begin
                partial_nxt = unv_pkg::POINT_W'(q_head.data[3:0]);
                pending_nxt = 2'd2;
              end
              unv_pkg::KIND_LEAD2: begin
                partial_nxt = unv_pkg::POINT_W'(q_head.data[4:0]);
                pending_nxt = 2'd1;
              end
              unv_pkg::KIND_SINGLE: begin
                finish = 1'b1;
                cp     = unv_pkg::POINT_W'(q_head.data);
              end
              default: failed_nxt = 1'b1;
            endcase
          end else if (!q_head.cont_ok) begin
            failed_nxt = 1'b1;
          end else begin
            partial_nxt = shifted;
            pending_nxt = pending_r - 2'd1;
            if (pending_r == 2'd1) begin
              finish = 1'b1;
              cp     = shifted;
            end
          end
        end
      end

      if (finish) begin
        if (count_r != unv_pkg::COUNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        if (!is_invisible(cp)) begin
          visible_nxt = 1'b1;
        end
      end

      if (q_head.last) begin
        out_valid_nxt                 = 1'b1;
        out_item_nxt.name_valid       = any_byte_nxt & ~failed_nxt &
                                        (pending_nxt == 2'd0) & visible_nxt &
                                        (count_nxt <= unv_pkg::COUNT_W'(limit_r));
        out_item_nxt.code_point_total = count_nxt;
        out_item_nxt.visible_found    = visible_nxt;
        pending_nxt  = '0;
        partial_nxt  = '0;
        count_nxt    = '0;
        visible_nxt  = 1'b0;
        failed_nxt   = 1'b0;
        any_byte_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= unv_pkg::LIMIT_RESET;
      pending_r   <= '0;
      partial_r   <= '0;
      count_r     <= '0;
      visible_r   <= 1'b0;
      failed_r    <= 1'b0;
      any_byte_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      pending_r   <= pending_nxt;
      partial_r   <= partial_nxt;
      count_r     <= count_nxt;
      visible_r   <= visible_nxt;
      failed_r    <= failed_nxt;
      any_byte_r  <= any_byte_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
